### sv/twtc_pkg.sv
// shared types, constants and helpers of the trigger cluster block
package twtc_pkg;

  localparam int unsigned TIME_BITS = 62;
  localparam int unsigned WIN_BITS  = 62;
  localparam int unsigned Q_BITS    = 24;
  localparam int unsigned CNT_BITS  = 32;
  localparam int unsigned SQ_BITS   = 2 * Q_BITS;
  localparam int unsigned ACC_BITS  = 4 * Q_BITS;
  localparam int unsigned CFG_DW    = WIN_BITS;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CMP_BITS  = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [Q_BITS-1:0]    q_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_NS = 1'b0,
    REG_STAT_MODE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_SNR   = 2'd0,
    MODE_RATIO = 2'd1,
    MODE_NONE  = 2'd2
  } stat_mode_e;

  typedef enum logic {
    MAC_LOAD   = 1'b0,
    MAC_ADD_SH = 1'b1
  } mac_op_e;

  typedef struct packed {
    logic    en;
    mac_op_e op;
    q_t      a;
    q_t      b;
  } mac_req_t;

  typedef struct packed {
    time_t end_time_ns;
    q_t    snr;
    q_t    chisq;
    logic  last_in;
  } in_beat_t;

  typedef struct packed {
    time_t kept_time_ns;
    q_t    kept_snr;
    q_t    kept_chisq;
    cnt_t  cluster_number;
    logic  final_out;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SQN,
    ST_SQW,
    ST_X0,
    ST_X1,
    ST_Y0,
    ST_Y1,
    ST_CMP,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == '1) ? c : c + cnt_t'(1);
  endfunction

endpackage

### sv/twtc_mac.sv
// shared 24x24 multiplier with shifted accumulate
module twtc_mac
  import twtc_pkg::*;
(
  input  logic                clk_i,
  input  mac_req_t            req_i,
  output logic [ACC_BITS-1:0] acc_o
);

  logic [SQ_BITS-1:0]  prod;
  logic [ACC_BITS-1:0] acc_d, acc_q;

  assign prod = SQ_BITS'(req_i.a) * SQ_BITS'(req_i.b);

  always_comb begin
    acc_d = acc_q;
    if (req_i.en) begin
      case (req_i.op)
        MAC_LOAD:   acc_d = ACC_BITS'(prod);
        MAC_ADD_SH: acc_d = acc_q + ACC_BITS'({prod, Q_BITS'(0)});
        default:    acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

### sv/time_window_trigger_cluster_core.sv
// top level: time-window peak clustering of a sorted trigger stream
//
// usage
//   triggers come in on the in channel (valid/ready), one beat per trigger,
//   sorted by end time. cluster winners leave on the out channel, one beat
//   per finished cluster; a trigger with last_in set flushes the held winner
//   with final_out set, so one input beat gives zero, one or two output beats.
//   the user writes window_ns and stat_mode on the plain write port while idle.
// timing
//   in_ready is high only in the idle state. an accepted trigger goes to eval,
//   then to idle or flush; one that closes a cluster first passes through emit;
//   a trigger inside the window in snr-squared-over-chisq mode with both chisq
//   nonzero first makes six passes through the one 24x24 multiply-accumulate
//   unit, states sqn to y1, plus a 96-bit compare in cmp. a flush comes last.
//   an output beat appears in the out register the cycle after it is formed.
// reset
//   asynchronous, active low: no winner held, cluster count zero, registers
//   cleared to window 0 and snr mode, out channel empty.
// back-pressure
//   the out register holds its beat until taken; a sequencer that needs to
//   emit while it is still full waits in place, so nothing is lost.
module time_window_trigger_cluster_core
  import twtc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_data_i
);

  state_e state_d, state_q;

  // configuration
  logic [WIN_BITS-1:0] window_q;
  logic [1:0]          mode_q;

  // captured trigger
  in_beat_t in_d, in_q;

  // current cluster winner
  logic  win_valid_d, win_valid_q;
  time_t win_time_d, win_time_q;
  q_t    win_snr_d, win_snr_q;
  q_t    win_chisq_d, win_chisq_q;
  cnt_t  count_d, count_q;

  // products for the ratio compare
  logic [SQ_BITS-1:0]  sq_n_d, sq_n_q;
  logic [SQ_BITS-1:0]  sq_w_d, sq_w_q;
  logic [ACC_BITS-1:0] x_d, x_q;
  logic [ACC_BITS-1:0] mac_acc;
  mac_req_t            mac_req;

  // out register
  out_beat_t out_d, out_q;
  logic      out_valid_d, out_valid_q;

  // decisions
  time_t diff;
  logic  outside, need_mul, quick_beats, cmp_beats, out_free;
  state_e tail_st;

  twtc_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (mac_acc)
  );

  // config writes, taken on any cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      mode_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW_NS: window_q <= cfg_data_i[WIN_BITS-1:0];
        REG_STAT_MODE: mode_q   <= cfg_data_i[1:0];
      endcase
    end
  end

  // window test and statistic decisions
  always_comb begin
    diff        = in_q.end_time_ns - win_time_q;
    // time going backwards counts as inside any window
    outside     = !((in_q.end_time_ns < win_time_q) ||
                    (CMP_BITS'(diff) < CMP_BITS'(window_q)));
    need_mul    = 1'b0;
    quick_beats = 1'b0;
    case (stat_mode_e'(mode_q))
      MODE_SNR: quick_beats = in_q.snr > win_snr_q;
      MODE_RATIO: begin
        // zero chisq is an infinite statistic
        if (in_q.chisq == '0) begin
          quick_beats = win_chisq_q != '0;
        end else if (win_chisq_q != '0) begin
          need_mul = 1'b1;
        end
      end
      default: quick_beats = 1'b0;
    endcase
    cmp_beats = x_q > mac_acc;
    out_free  = !out_valid_q || out_ready_i;
    tail_st   = in_q.last_in ? ST_FLUSH : ST_IDLE;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL: begin
        if (!win_valid_q) begin
          state_d = tail_st;
        end else if (outside) begin
          state_d = ST_EMIT;
        end else if (need_mul) begin
          state_d = ST_SQN;
        end else begin
          state_d = tail_st;
        end
      end
      ST_SQN:   state_d = ST_SQW;
      ST_SQW:   state_d = ST_X0;
      ST_X0:    state_d = ST_X1;
      ST_X1:    state_d = ST_Y0;
      ST_Y0:    state_d = ST_Y1;
      ST_Y1:    state_d = ST_CMP;
      ST_CMP:   state_d = tail_st;
      ST_EMIT:  if (out_free) state_d = tail_st;
      ST_FLUSH: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready_o  = 1'b0;
    in_d        = in_q;
    win_valid_d = win_valid_q;
    win_time_d  = win_time_q;
    win_snr_d   = win_snr_q;
    win_chisq_d = win_chisq_q;
    count_d     = count_q;
    sq_n_d      = sq_n_q;
    sq_w_d      = sq_w_q;
    x_d         = x_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mac_req     = '{en: 1'b0, op: MAC_LOAD, a: '0, b: '0};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) in_d = in_i;
      end
      ST_EVAL: begin
        if (!win_valid_q || (!outside && !need_mul && quick_beats)) begin
          win_valid_d = 1'b1;
          win_time_d  = in_q.end_time_ns;
          win_snr_d   = in_q.snr;
          win_chisq_d = in_q.chisq;
        end
      end
      // snr_n^2 * chisq_w against snr_w^2 * chisq_n, 24 bits a pass
      ST_SQN: mac_req = '{en: 1'b1, op: MAC_LOAD, a: in_q.snr, b: in_q.snr};
      ST_SQW: begin
        mac_req = '{en: 1'b1, op: MAC_LOAD, a: win_snr_q, b: win_snr_q};
        sq_n_d  = mac_acc[SQ_BITS-1:0];
      end
      ST_X0: begin
        mac_req = '{en: 1'b1, op: MAC_LOAD, a: sq_n_q[Q_BITS-1:0], b: win_chisq_q};
        sq_w_d  = mac_acc[SQ_BITS-1:0];
      end
      ST_X1: mac_req = '{en: 1'b1, op: MAC_ADD_SH, a: sq_n_q[SQ_BITS-1:Q_BITS],
                         b: win_chisq_q};
      ST_Y0: begin
        mac_req = '{en: 1'b1, op: MAC_LOAD, a: sq_w_q[Q_BITS-1:0], b: in_q.chisq};
        x_d     = mac_acc;
      end
      ST_Y1: mac_req = '{en: 1'b1, op: MAC_ADD_SH, a: sq_w_q[SQ_BITS-1:Q_BITS],
                         b: in_q.chisq};
      ST_CMP: begin
        if (cmp_beats) begin
          win_time_d  = in_q.end_time_ns;
          win_snr_d   = in_q.snr;
          win_chisq_d = in_q.chisq;
        end
      end
      ST_EMIT: begin
        // close the cluster, the new trigger opens the next one
        if (out_free) begin
          count_d     = sat_inc(count_q);
          out_d       = '{kept_time_ns: win_time_q, kept_snr: win_snr_q,
                          kept_chisq: win_chisq_q, cluster_number: sat_inc(count_q),
                          final_out: 1'b0};
          out_valid_d = 1'b1;
          win_time_d  = in_q.end_time_ns;
          win_snr_d   = in_q.snr;
          win_chisq_d = in_q.chisq;
        end
      end
      ST_FLUSH: begin
        // end of stream: emit and start counting afresh
        if (out_free) begin
          out_d       = '{kept_time_ns: win_time_q, kept_snr: win_snr_q,
                          kept_chisq: win_chisq_q, cluster_number: sat_inc(count_q),
                          final_out: 1'b1};
          out_valid_d = 1'b1;
          win_valid_d = 1'b0;
          count_d     = '0;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_valid_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_valid_q <= win_valid_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    win_time_q  <= win_time_d;
    win_snr_q   <= win_snr_d;
    win_chisq_q <= win_chisq_d;
    sq_n_q      <= sq_n_d;
    sq_w_q      <= sq_w_d;
    x_q         <= x_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### sv/twtc_checker.sv
// port-level checks of the trigger cluster block, bound to the top level
module twtc_checker
  import twtc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_beat_t out_o
);

  // a trigger keeps the sequencer busy in the cycle after it is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready high right after an accepted beat");

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output beat changed while stalled");

  // cluster numbers start at one
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.cluster_number != '0)
    else $error("cluster number zero on an output beat");

endmodule

bind time_window_trigger_cluster_core twtc_checker u_twtc_checker (.*);
